>>> design/slfp_pkg.sv
// ----------------------------------------------------------------------------
// slfp_pkg: shared types and constants for the sync/length frame parser
// Parse phases, sync byte values and the item record passed from the input
// register to the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 16;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hD0;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h0D;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // One received byte held in the input register.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

endpackage

`default_nettype wire

>>> design/slfp_rx_if.sv
// ----------------------------------------------------------------------------
// slfp_rx_if: received byte channel
// Valid/ready channel that carries one raw link byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface slfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/slfp_msg_if.sv
// ----------------------------------------------------------------------------
// slfp_msg_if: payload byte channel
// Valid/ready channel that carries one payload byte and its message marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface slfp_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_of_message;
  logic       last_of_message;

  modport source (output valid, output payload_byte, output first_of_message,
                  output last_of_message, input ready);
  modport sink   (input valid, input payload_byte, input first_of_message,
                  input last_of_message, output ready);
endinterface

`default_nettype wire

>>> design/slfp_input_stage.sv
// ----------------------------------------------------------------------------
// slfp_input_stage: input register
// Captures one received byte per transfer and holds it until the parser
// takes it. Refills in the same cycle the held byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module slfp_input_stage (
  input  logic              clk,
  input  logic              rst,
  slfp_rx_if.sink           rx,
  input  logic              take,
  output slfp_pkg::rx_item_t item
);
  import slfp_pkg::*;

  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;

  assign rx.ready     = !held_valid || take;
  assign item.valid   = held_valid;
  assign item.rx_byte = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx.ready) begin
      held_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      held_byte <= rx.rx_byte;
    end
  end

endmodule

`default_nettype wire

>>> design/slfp_parser.sv
// ----------------------------------------------------------------------------
// slfp_parser: frame state machine and result register
// Hunts for the sync pair, collects the little-endian length and streams
// the payload bytes into the output register with first and last marks.
// ----------------------------------------------------------------------------
`default_nettype none

module slfp_parser (
  input  logic               clk,
  input  logic               rst,
  input  slfp_pkg::rx_item_t item,
  output logic               take,
  slfp_msg_if.source         msg
);
  import slfp_pkg::*;

  phase_t               parse_phase, parse_phase_next;
  logic [BYTE_W-1:0]    length_low, length_low_next;
  logic [COUNT_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic                 at_payload_start, at_payload_start_next;
  logic [COUNT_W-1:0]   frame_len;

  logic                 emit;
  logic                 emit_last;

  logic                 out_valid;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_first;
  logic                 out_last;

  assign take      = item.valid && (!out_valid || msg.ready);
  assign frame_len = {item.rx_byte, length_low};

  // Next-state logic.
  always_comb begin
    parse_phase_next      = parse_phase;
    length_low_next       = length_low;
    bytes_remaining_next  = bytes_remaining;
    at_payload_start_next = at_payload_start;
    case (parse_phase)
      PH_SYNC1: begin
        parse_phase_next = (item.rx_byte == SYNC_SECOND) ? PH_LEN_LO : PH_HUNT;
      end
      PH_LEN_LO: begin
        length_low_next  = item.rx_byte;
        parse_phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (frame_len == '0) begin
          parse_phase_next = PH_HUNT;
        end else begin
          bytes_remaining_next  = frame_len;
          at_payload_start_next = 1'b1;
          parse_phase_next      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        at_payload_start_next = 1'b0;
        if (bytes_remaining == '0) begin
          parse_phase_next = PH_HUNT;
        end else begin
          bytes_remaining_next = bytes_remaining - COUNT_W'(1);
          if (bytes_remaining == COUNT_W'(1)) begin
            parse_phase_next = PH_HUNT;
          end
        end
      end
      default: begin
        parse_phase_next = (item.rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    case (parse_phase)
      PH_PAYLOAD: begin
        emit      = (bytes_remaining != '0);
        emit_last = (bytes_remaining == COUNT_W'(1));
      end
      default: begin
        emit      = 1'b0;
        emit_last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_HUNT;
      length_low       <= '0;
      bytes_remaining  <= '0;
      at_payload_start <= 1'b0;
    end else if (take) begin
      parse_phase      <= parse_phase_next;
      length_low       <= length_low_next;
      bytes_remaining  <= bytes_remaining_next;
      at_payload_start <= at_payload_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (msg.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_byte  <= item.rx_byte;
      out_first <= at_payload_start;
      out_last  <= emit_last;
    end
  end

  assign msg.valid            = out_valid;
  assign msg.payload_byte     = out_byte;
  assign msg.first_of_message = out_first;
  assign msg.last_of_message  = out_last;

  // The payload phase always has at least one byte left to deliver.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_PAYLOAD) |-> (bytes_remaining != '0))
    else $error("payload phase with no bytes remaining");

  // The first-byte mark only exists inside a payload.
  a_start_in_payload: assert property (@(posedge clk) disable iff (rst)
    at_payload_start |-> (parse_phase == PH_PAYLOAD))
    else $error("first-byte mark outside payload phase");

  // After the last payload byte goes out, the hunt resumes.
  a_last_returns_hunt: assert property (@(posedge clk) disable iff (rst)
    (take && emit && emit_last) |=> (parse_phase == PH_HUNT))
    else $error("parser did not return to hunt after last byte");

  // A new byte is only taken when the result register has room.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    take |-> (!out_valid || msg.ready))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

>>> design/sync_length_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_length_frame_parser: sync-word, length-prefixed deframer
// Finds the 0xD0 0x0D sync pair, reads a 16-bit little-endian length and
// streams that many payload bytes with first and last marks.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+--------------------------------------------------------
//  rx      | in  | rx_byte[7:0]
//  msg     | out | payload_byte[7:0], first_of_message, last_of_message
//
//  One byte is taken per cycle while msg is not stalled; a payload byte
//  passes through the input register, then the result register, before it
//  is offered on msg.
//  Sync, length and dropped bytes produce no msg transfer.
//  A stall on msg holds the result register; rx keeps accepting until the
//  input register is also full.
//  Synchronous reset returns the parser to the hunt and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_frame_parser (
  input  logic       clk,
  input  logic       rst,
  slfp_rx_if.sink    rx,
  slfp_msg_if.source msg
);
  import slfp_pkg::*;

  rx_item_t item;
  logic     take;

  slfp_input_stage u_input_stage (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .item (item)
  );

  slfp_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .take (take),
    .msg  (msg)
  );

endmodule

`default_nettype wire
